/* rtl/sxor_pkg.sv */
package sxor_pkg;

  // one keystream block as sixteen 32-bit words, word i at [i]
  typedef logic [15:0][31:0] block_t;

  // salsa20 sigma constants
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // rotate amounts of the four arx steps of a quarter round
  localparam int unsigned ROT_B = 7;
  localparam int unsigned ROT_C = 9;
  localparam int unsigned ROT_D = 13;
  localparam int unsigned ROT_A = 18;

  // arx step codes within a quarter round
  localparam logic [1:0] STEP_B = 2'd0;
  localparam logic [1:0] STEP_C = 2'd1;
  localparam logic [1:0] STEP_D = 2'd2;
  localparam logic [1:0] STEP_A = 2'd3;

endpackage

/* rtl/salsa20_stream_xor.sv */
// channel  | handshake            | payload
// ---------+----------------------+-------------------
// input    | in_valid / in_ready  | msg_byte, last_byte
// output   | out_valid / out_ready| ct_byte, last_out
// config   | apb (psel, penable)  | paddr, pwdata, prdata
//
// a byte inside a keystream block goes straight out; a byte that opens a block
// waits for a new block, generated by the one shared add-rotate-xor unit doing
// one step of a quarter round per cycle
// rst is synchronous and active high; the next message starts at start_counter
// a result held by a stalled receiver keeps the input from taking the next byte
module salsa20_stream_xor #(
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  // output bytes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  ct_byte,
  output logic        last_out
);

  // register map, 8 bytes apart
  typedef enum logic [2:0] {
    REG_KEY01  = 3'd0,
    REG_KEY23  = 3'd1,
    REG_KEY45  = 3'd2,
    REG_KEY67  = 3'd3,
    REG_NONCE  = 3'd4,
    REG_ROUNDS = 3'd5,
    REG_START  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_GEN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // configuration registers
  logic [3:0][63:0] key_words;
  logic [63:0]      nonce_value;
  logic [4:0]       round_count;
  logic [63:0]      start_counter;

  // stream state
  state_t           state;
  logic [5:0]       byte_position;
  logic [63:0]      block_counter;
  logic             keystream_valid;
  logic [7:0]       item_byte;
  logic             item_last;

  sxor_pkg::block_t ks_words;
  logic             core_done;
  logic             cfg_write;
  reg_idx_t         cfg_idx;
  logic             in_accept;
  logic             need_block;
  logic             out_free;
  logic             emit;
  logic             emit_last;
  logic [7:0]       emit_byte;
  logic [31:0]      ks_word;
  logic [7:0]       ks_byte;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words     <= '0;
      nonce_value   <= '0;
      round_count   <= 5'd20;
      start_counter <= 64'd1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_KEY01:  key_words[0]  <= pwdata;
        REG_KEY23:  key_words[1]  <= pwdata;
        REG_KEY45:  key_words[2]  <= pwdata;
        REG_KEY67:  key_words[3]  <= pwdata;
        REG_NONCE:  nonce_value   <= pwdata;
        REG_ROUNDS: round_count   <= pwdata[4:0];
        REG_START:  start_counter <= pwdata;
        default: ; // beyond the map: ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY01:  prdata = key_words[0];
      REG_KEY23:  prdata = key_words[1];
      REG_KEY45:  prdata = key_words[2];
      REG_KEY67:  prdata = key_words[3];
      REG_NONCE:  prdata = nonce_value;
      REG_ROUNDS: prdata = {59'd0, round_count};
      REG_START:  prdata = start_counter;
      default:    prdata = '0;
    endcase
  end

  // keystream generator, started in ST_LOAD, the cycle after the counter settles
  sxor_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LOAD),
    .key      (key_words),
    .nonce    (nonce_value),
    .rounds   (round_count),
    .ctr      (block_counter),
    .done     (core_done),
    .ks_words (ks_words)
  );

  // the output register frees up when empty or when its transaction completes
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE) && out_free;
  assign in_accept  = in_valid && in_ready;
  // a new message or a block boundary needs a fresh keystream block
  assign need_block = !keystream_valid || (byte_position == 6'd0);

  // bytes inside a block go straight out; others after generation
  assign emit      = (in_accept && !need_block) || ((state == ST_EMIT) && out_free);
  assign emit_byte = (state == ST_EMIT) ? item_byte : msg_byte;
  assign emit_last = (state == ST_EMIT) ? item_last : last_byte;

  // little-endian byte pick from the current keystream word
  assign ks_word = ks_words[byte_position[5:2]];
  assign ks_byte = 8'(ks_word >> {byte_position[1:0], 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      byte_position   <= '0;
      block_counter   <= 64'd1;
      keystream_valid <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && need_block) begin
            if (!keystream_valid) begin
              block_counter <= start_counter;
              byte_position <= '0;
            end
            keystream_valid <= 1'b1;
            state           <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_GEN;
        end
        ST_GEN: begin
          if (core_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (emit) begin
        out_valid <= 1'b1;
        if (emit_last) begin
          // end of message: next byte starts over at start_counter
          byte_position   <= '0;
          keystream_valid <= 1'b0;
        end else begin
          byte_position <= byte_position + 6'd1;
          if (byte_position == 6'd63) begin
            block_counter <= block_counter + 64'd1;
          end
        end
      end
    end
  end

  // output payload and the held item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_byte <= msg_byte;
      item_last <= last_byte;
    end
    if (emit) begin
      ct_byte  <= emit_byte ^ ks_byte;
      last_out <= emit_last;
    end
  end

`ifndef SYNTH
  // the generator only finishes while an item waits for its block
  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    core_done |-> (state == ST_GEN))
    else $error("keystream done outside generation");

  // between messages the byte position rests at zero
  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    !keystream_valid |-> (byte_position == 6'd0))
    else $error("byte position set with no message open");

  // a new message loads the counter from start_counter
  a_ctr_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !keystream_valid) |=>
      (block_counter == $past(start_counter)))
    else $error("block counter not loaded at message start");

  // a byte inside a block is answered at once
  a_direct: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && keystream_valid && (byte_position != 6'd0)) |=>
      (out_valid && (state == ST_IDLE)))
    else $error("byte inside block not answered");
`endif

endmodule

/* rtl/sxor_core.sv */
module sxor_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0][63:0]     key,
  input  logic [63:0]          nonce,
  input  logic [4:0]           rounds,
  input  logic [63:0]          ctr,
  output logic                 done,
  output sxor_pkg::block_t     ks_words
);

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_RUN  = 3'b010,
    CS_FIN  = 3'b100
  } core_state_t;

  core_state_t      state;
  sxor_pkg::block_t work;
  sxor_pkg::block_t in_blk;
  sxor_pkg::block_t fin_blk;
  logic [3:0]       step;
  logic             half;
  logic [3:0]       dr_left;

  function automatic sxor_pkg::block_t make_input(input logic [3:0][63:0] k,
                                                  input logic [63:0] n,
                                                  input logic [63:0] c);
    sxor_pkg::block_t b;
    b[0]  = sxor_pkg::SIGMA0;
    b[1]  = k[0][31:0];
    b[2]  = k[0][63:32];
    b[3]  = k[1][31:0];
    b[4]  = k[1][63:32];
    b[5]  = sxor_pkg::SIGMA1;
    b[6]  = n[31:0];
    b[7]  = n[63:32];
    b[8]  = c[31:0];
    b[9]  = c[63:32];
    b[10] = sxor_pkg::SIGMA2;
    b[11] = k[2][31:0];
    b[12] = k[2][63:32];
    b[13] = k[3][31:0];
    b[14] = k[3][63:32];
    b[15] = sxor_pkg::SIGMA3;
    return b;
  endfunction

  // column c rotated up by c: each column quarter round lands in rows 0..3
  function automatic sxor_pkg::block_t skew(input sxor_pkg::block_t n);
    sxor_pkg::block_t w;
    logic [1:0] r2;
    logic [1:0] c2;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        r2 = 2'(r);
        c2 = 2'(c);
        w[{r2, c2}] = n[{2'(r2 + c2), c2}];
      end
    end
    return w;
  endfunction

  function automatic sxor_pkg::block_t unskew(input sxor_pkg::block_t w);
    sxor_pkg::block_t n;
    logic [1:0] r2;
    logic [1:0] c2;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        r2 = 2'(r);
        c2 = 2'(c);
        n[{r2, c2}] = w[{2'(r2 - c2), c2}];
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [1:0] sel);
    logic [31:0] res;
    case (sel)
      sxor_pkg::STEP_B: res = (v << sxor_pkg::ROT_B) | (v >> (32 - sxor_pkg::ROT_B));
      sxor_pkg::STEP_C: res = (v << sxor_pkg::ROT_C) | (v >> (32 - sxor_pkg::ROT_C));
      sxor_pkg::STEP_D: res = (v << sxor_pkg::ROT_D) | (v >> (32 - sxor_pkg::ROT_D));
      sxor_pkg::STEP_A: res = (v << sxor_pkg::ROT_A) | (v >> (32 - sxor_pkg::ROT_A));
      default:          res = v;
    endcase
    return res;
  endfunction

  // the shared unit: one add-rotate-xor on fixed places, then fixed permutations
  function automatic sxor_pkg::block_t arx_step(input sxor_pkg::block_t w,
                                                input logic [3:0] s);
    sxor_pkg::block_t x;
    sxor_pkg::block_t y;
    sxor_pkg::block_t z;
    logic [31:0] t;
    logic [1:0] r2;
    logic [1:0] c2;
    t = w[4] ^ rotl(w[0] + w[12], s[1:0]);
    x = w;
    // roles move round column 0: b becomes the next a
    x[0]  = t;
    x[4]  = w[8];
    x[8]  = w[12];
    x[12] = w[0];
    y = x;
    if (s[1:0] == sxor_pkg::STEP_A) begin
      // bring the next quarter round into column 0
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          r2 = 2'(r);
          c2 = 2'(c);
          y[{r2, c2}] = x[{r2, 2'(c2 + 2'd1)}];
        end
      end
    end
    z = y;
    if (s == 4'hf) begin
      // swap between column layout and row layout
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          r2 = 2'(r);
          c2 = 2'(c);
          z[{r2, c2}] = y[{2'(2'd0 - r2), 2'(r2 + c2)}];
        end
      end
    end
    return z;
  endfunction

  assign in_blk  = make_input(key, nonce, ctr);
  assign fin_blk = unskew(work);
  assign done    = (state == CS_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CS_IDLE;
      step    <= '0;
      half    <= 1'b0;
      dr_left <= '0;
    end else begin
      case (state)
        CS_IDLE: begin
          if (start) begin
            step    <= '0;
            half    <= 1'b0;
            dr_left <= rounds[4:1];
            state   <= (rounds[4:1] == 4'd0) ? CS_FIN : CS_RUN;
          end
        end
        CS_RUN: begin
          step <= step + 4'd1;
          if (step == 4'hf) begin
            half <= ~half;
            if (half) begin
              dr_left <= dr_left - 4'd1;
              if (dr_left == 4'd1) begin
                state <= CS_FIN;
              end
            end
          end
        end
        CS_FIN: begin
          state <= CS_IDLE;
        end
        default: begin
          state <= CS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == CS_IDLE && start) begin
      work <= skew(in_blk);
    end else if (state == CS_RUN) begin
      work <= arx_step(work, step);
    end
  end

  always_ff @(posedge clk) begin
    if (state == CS_FIN) begin
      for (int i = 0; i < 16; i++) begin
        ks_words[i] <= fin_blk[i] + in_blk[i];
      end
    end
  end

endmodule

/* test/salsa_tb_pkg.sv */
`timescale 1ns / 100ps

package salsa_tb_pkg;

  // register indexes of the apb port, register i at byte address 8 * i
  localparam logic [2:0] REG_KEY01  = 3'd0;
  localparam logic [2:0] REG_KEY23  = 3'd1;
  localparam logic [2:0] REG_KEY45  = 3'd2;
  localparam logic [2:0] REG_KEY67  = 3'd3;
  localparam logic [2:0] REG_NONCE  = 3'd4;
  localparam logic [2:0] REG_ROUNDS = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;
  // past the end of the register map, writes are dropped
  localparam logic [2:0] REG_SPARE  = 3'd7;

endpackage

/* test/salsa20_xor_checker.sv */
`timescale 1ns / 100ps

module salsa20_xor_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  ct_byte,
  input  logic        last_out,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [7:0] ct;
    logic       fin;
  } cipher_byte_t;

  cipher_byte_t cipher_q[$];

  // register copies
  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_r;
  logic [4:0]       rounds_r;
  logic [63:0]      start_r;

  // keystream state
  sxor_pkg::block_t stream_r;
  logic [5:0]       pos_r;
  logic [63:0]      ctr_r;
  logic             active_r;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic sxor_pkg::block_t quarter(input sxor_pkg::block_t x, input int a,
                                               input int b, input int c, input int d);
    x[b] = x[b] ^ rotl32(x[a] + x[d], sxor_pkg::ROT_B);
    x[c] = x[c] ^ rotl32(x[b] + x[a], sxor_pkg::ROT_C);
    x[d] = x[d] ^ rotl32(x[c] + x[b], sxor_pkg::ROT_D);
    x[a] = x[a] ^ rotl32(x[d] + x[c], sxor_pkg::ROT_A);
    return x;
  endfunction

  function automatic sxor_pkg::block_t salsa_core(input logic [3:0][63:0] key,
                                                  input logic [63:0] nonce,
                                                  input logic [63:0] ctr,
                                                  input logic [4:0] rounds);
    sxor_pkg::block_t init;
    sxor_pkg::block_t x;
    init[0]  = sxor_pkg::SIGMA0;
    init[1]  = key[0][31:0];
    init[2]  = key[0][63:32];
    init[3]  = key[1][31:0];
    init[4]  = key[1][63:32];
    init[5]  = sxor_pkg::SIGMA1;
    init[6]  = nonce[31:0];
    init[7]  = nonce[63:32];
    init[8]  = ctr[31:0];
    init[9]  = ctr[63:32];
    init[10] = sxor_pkg::SIGMA2;
    init[11] = key[2][31:0];
    init[12] = key[2][63:32];
    init[13] = key[3][31:0];
    init[14] = key[3][63:32];
    init[15] = sxor_pkg::SIGMA3;
    x = init;
    // bit 0 of the round count plays no part
    for (int dr = 0; dr < rounds[4:1]; dr++) begin
      x = quarter(x, 0, 4, 8, 12);
      x = quarter(x, 5, 9, 13, 1);
      x = quarter(x, 10, 14, 2, 6);
      x = quarter(x, 15, 3, 7, 11);
      x = quarter(x, 0, 1, 2, 3);
      x = quarter(x, 5, 6, 7, 4);
      x = quarter(x, 10, 11, 8, 9);
      x = quarter(x, 15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) x[i] = x[i] + init[i];
    return x;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    cipher_byte_t want;
    logic [31:0]  word;
    logic [7:0]   ks_byte;
    if (rst) begin
      key_r      = '0;
      nonce_r    = '0;
      rounds_r   = 5'd20;
      start_r    = 64'd1;
      stream_r   = '0;
      pos_r      = '0;
      ctr_r      = 64'd1;
      active_r   = 1'b0;
      mismatches = 0;
      cipher_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          salsa_tb_pkg::REG_KEY01:  key_r[0] = pwdata;
          salsa_tb_pkg::REG_KEY23:  key_r[1] = pwdata;
          salsa_tb_pkg::REG_KEY45:  key_r[2] = pwdata;
          salsa_tb_pkg::REG_KEY67:  key_r[3] = pwdata;
          salsa_tb_pkg::REG_NONCE:  nonce_r  = pwdata;
          salsa_tb_pkg::REG_ROUNDS: rounds_r = pwdata[4:0];
          salsa_tb_pkg::REG_START:  start_r  = pwdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          note_failure($sformatf("unexpected result ct_byte %h last_out %b", ct_byte, last_out));
        end else begin
          want = cipher_q.pop_front();
          if (ct_byte !== want.ct || last_out !== want.fin)
            note_failure($sformatf("mismatch: ct_byte exp %h got %h, last_out exp %b got %b",
                                   want.ct, ct_byte, want.fin, last_out));
        end
      end

      if (in_valid && in_ready) begin
        if (!active_r) begin
          ctr_r    = start_r;
          active_r = 1'b1;
          pos_r    = '0;
        end
        if (pos_r == 6'd0) stream_r = salsa_core(key_r, nonce_r, ctr_r, rounds_r);
        word    = stream_r[pos_r[5:2]];
        ks_byte = word[{pos_r[1:0], 3'b000} +: 8];
        want.ct  = msg_byte ^ ks_byte;
        want.fin = last_byte;
        cipher_q.push_back(want);
        if (last_byte) begin
          pos_r    = '0;
          active_r = 1'b0;
        end else begin
          pos_r = pos_r + 6'd1;
          if (pos_r == 6'd0) ctr_r = ctr_r + 64'd1;
        end
      end
    end
    pending = cipher_q.size();
  end

endmodule

/* test/tb_salsa20_stream_xor.sv */
`timescale 1ns / 100ps

module tb_salsa20_stream_xor;

  // random part length and the long receiver hold-off
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 400;
  // tail wait, sized for a block opening byte at 31 rounds
  localparam int TAIL_CYCLES  = 600;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_MOSTLY,
    RX_SLOW
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  msg_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  ct_byte;
  logic        last_out;

  int mismatches;
  int pending;

  // sender burst state, and the request for a long receiver hold-off
  int       burst_left;
  int       bytes_sent;
  logic     no_gaps;
  logic     hold_req;
  rx_mode_t rx_mode;
  int       rx_left;

  salsa20_stream_xor dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .msg_byte  (msg_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ct_byte   (ct_byte),
    .last_out  (last_out)
  );

  // watches all three ports, predicts each output transaction and compares
  salsa20_xor_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .msg_byte   (msg_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ct_byte    (ct_byte),
    .last_out   (last_out),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern changes at random intervals, with the odd
  // long hold-off on request so the block backs up into its input
  initial begin
    out_ready = 1'b0;
    rx_mode   = RX_FREE;
    rx_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:   out_ready = 1'b1;
        RX_COIN:   out_ready = $urandom_range(0, 1);
        RX_MOSTLY: out_ready = ($urandom_range(0, 7) != 0);
        RX_SLOW:   out_ready = (rx_left % 4 == 0);
        default:   out_ready = 1'b1;
      endcase
    end
  end

  // apb write: setup cycle then access cycle, inputs move on falling edges
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // offer one byte; a random gap opens before each new burst. valid stays
  // high on return so back-to-back transactions have no bubble
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  = 1'b1;
    msg_byte  = b;
    last_byte = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering and wait until every predicted byte has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [4:0] pick_rounds();
    case ($urandom_range(0, 5))
      0:       return 5'd8;
      1:       return 5'd12;
      2:       return 5'd20;
      3:       return 5'd2;
      4:       return 5'd4;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // random settings, each register touched with even odds
  task automatic shuffle_config();
    logic [63:0] val;
    for (int r = salsa_tb_pkg::REG_KEY01; r <= salsa_tb_pkg::REG_START; r++) begin
      if ($urandom_range(0, 1)) begin
        val = {$urandom, $urandom};
        if (r == salsa_tb_pkg::REG_ROUNDS) val = 64'(pick_rounds());
        // counter close to the wrap point now and then
        if (r == salsa_tb_pkg::REG_START && $urandom_range(0, 3) == 0)
          val = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
        write_reg(3'(r), val);
      end
    end
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 7))
      0:       return 1;
      5:       return $urandom_range(31, 70);
      6:       return $urandom_range(63, 65);
      default: return $urandom_range(2, 30);
    endcase
  endfunction

  initial begin
    int phase;
    int n_msg;
    int len;
    logic close_msg;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    msg_byte   = '0;
    last_byte  = 1'b0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    burst_left = 0;
    bytes_sent = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part ---

    // reset settings: zero key and nonce, 20 rounds, counter from 1
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    // message of a single byte
    send_byte(8'h80, 1'b1);
    drain();

    // every register written, 8 rounds, counter from zero
    write_reg(salsa_tb_pkg::REG_KEY01, 64'h0706_0504_0302_0100);
    write_reg(salsa_tb_pkg::REG_KEY23, 64'h0f0e_0d0c_0b0a_0908);
    write_reg(salsa_tb_pkg::REG_KEY45, 64'h1716_1514_1312_1110);
    write_reg(salsa_tb_pkg::REG_KEY67, 64'h1f1e_1d1c_1b1a_1918);
    write_reg(salsa_tb_pkg::REG_NONCE, 64'h0123_4567_89ab_cdef);
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd8);
    write_reg(salsa_tb_pkg::REG_START, 64'd0);
    // index past the map must leave everything as it is
    write_reg(salsa_tb_pkg::REG_SPARE, 64'hffff_ffff_ffff_ffff);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // no double rounds at all: keystream is the input block doubled
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b1);
    drain();
    // odd count, low bit dropped
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd1);
    send_byte(8'hfe, 1'b1);
    drain();
    // largest count the field holds
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd31);
    send_byte(8'h10, 1'b1);
    drain();
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd12);
    send_byte(8'h20, 1'b0);
    send_byte(8'h40, 1'b1);
    drain();

    // all-ones key, nonce and counter at 20 rounds
    write_reg(salsa_tb_pkg::REG_KEY01, 64'hffff_ffff_ffff_ffff);
    write_reg(salsa_tb_pkg::REG_KEY23, 64'hffff_ffff_ffff_ffff);
    write_reg(salsa_tb_pkg::REG_KEY45, 64'hffff_ffff_ffff_ffff);
    write_reg(salsa_tb_pkg::REG_KEY67, 64'hffff_ffff_ffff_ffff);
    write_reg(salsa_tb_pkg::REG_NONCE, 64'hffff_ffff_ffff_ffff);
    write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd20);
    write_reg(salsa_tb_pkg::REG_START, 64'hffff_ffff_ffff_ffff);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);

    // --- random part ---
    // each phase drains, reconfigures, then sends a handful of messages.
    // the last message of a phase is sometimes left open so a key change
    // lands mid-message and must only show from the next block on
    bytes_sent = 0;
    phase = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      drain();
      if (phase == 0) begin
        // counter at its top value, long message runs across the wrap
        write_reg(salsa_tb_pkg::REG_ROUNDS, 64'd8);
        write_reg(salsa_tb_pkg::REG_START, 64'hffff_ffff_ffff_ffff);
      end else begin
        shuffle_config();
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while the sender keeps pushing
      if (phase == 1 || phase == 4) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      n_msg = $urandom_range(1, 4);
      for (int m = 0; m < n_msg; m++) begin
        len = pick_length();
        if (phase == 0 && m == 0) len = 130;
        if ((phase == 1 || phase == 4) && m == 0) len = 48;
        close_msg = !(m == n_msg - 1 && $urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom_range(0, 255)), close_msg && i == len - 1);
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sxor_pkg.sv
rtl/sxor_core.sv
rtl/salsa20_stream_xor.sv
test/salsa_tb_pkg.sv
test/salsa20_xor_checker.sv
test/tb_salsa20_stream_xor.sv
